// ----- rtl/core/eafrx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eafrx_pkg - shared types and constants of the escaped frame receive parser
// Byte codes of the framing, the header field slots, and the word that
// the framing front end hands to the header/output back end.
// ----------------------------------------------------------------------------
package eafrx_pkg;

  localparam logic [7:0] StartDelim = 8'h7E;
  localparam logic [7:0] EscByte    = 8'h7D;
  localparam logic [7:0] XonByte    = 8'h11;
  localparam logic [7:0] XoffByte   = 8'h13;
  localparam logic [7:0] EscXor     = 8'h20;

  localparam int unsigned IdxW     = 17;  // byte count, holds length + 3
  localparam int unsigned HdrBytes = 13;  // header bytes, payload starts after
  localparam int unsigned EndOfs   = 3;   // checksum sits at count length + 3

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam int unsigned OutDataW = 112;  // 14 bytes of result fields

  // Header field a byte belongs to
  typedef enum logic [3:0] {
    SLOT_NONE,
    SLOT_LEN_HI,
    SLOT_LEN_LO,
    SLOT_TYPE,
    SLOT_ADDR,
    SLOT_DPORT_HI,
    SLOT_DPORT_LO,
    SLOT_SPORT_HI,
    SLOT_SPORT_LO,
    SLOT_PROTO,
    SLOT_STATUS
  } slot_e;

  // One classified, unescaped frame byte
  typedef struct packed {
    logic [7:0] data;
    slot_e      slot;
    logic       emit;  // byte gives a result
    logic       last;  // byte closes the frame
  } word_t;

  // Restore an escaped byte; values outside the escaped set pass unchanged
  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    r = b ^ EscXor;
    if (r == StartDelim || r == EscByte || r == XonByte || r == XoffByte) begin
      return r;
    end
    return b;
  endfunction

endpackage : eafrx_pkg
`default_nettype wire

// ----- rtl/core/escaped_api_frame_rx_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_api_frame_rx_parser - receive parser for escaped API frames
// Takes serial bytes, strips framing and escapes, and streams out payload
// bytes together with the decoded frame header.
// ----------------------------------------------------------------------------
// Bytes arrive one per word on the slave stream. Outside a frame every byte
// but the 0x7E start delimiter is dropped. Inside a frame 0x7D escapes the
// next byte, which is XORed with 0x20 when that restores 0x7E, 0x7D, 0x11 or
// 0x13 and passed as is otherwise; 0x7E inside a frame is plain data. Frame
// bytes are counted from 1: 1-2 length (high first), 3 type, 4-7 IPv4 source
// address, 8-9 destination port, 10-11 source port, 12 protocol, 13 status.
// Every byte from 14 on leaves as one master word, and the byte at count
// length + 3 is the checksum: it leaves with tlast set (not checked) and
// closes the frame, even when it falls inside the header (short lengths).
// Each result word carries the header as it stands after that byte; fields
// not yet received in the current frame read zero.
// Throughput is one byte per clock while the master side takes words: the
// framing front end classifies a byte in the cycle it is taken, a two-word
// queue carries it to the back end, and the back end loads the header and
// the output register from the word at the queue head. Back pressure fills
// the output register and queue before s_axis_tready drops.
// ----------------------------------------------------------------------------
module escaped_api_frame_rx_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // slave stream: tdata = rx_byte[7:0]
  input  wire logic           s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire logic [7:0]     s_axis_tdata,
  // master stream, tdata from bit 0 up: payload_byte[7:0], frame_type[15:8],
  // source_address[47:16], destination_port[63:48], source_port[79:64],
  // protocol_code[87:80], status_code[95:88], frame_length[111:96]
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [111:0]        m_axis_tdata,
  output logic                m_axis_tlast  // frame_end
);
  import eafrx_pkg::*;

  logic  push;
  word_t push_word;
  logic  q_full;
  logic  q_valid;
  word_t q_word;
  logic  pop;

  // framing, escape removal, byte count and classification
  eafrx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .push_o       (push),
    .word_o       (push_word),
    .full_i       (q_full)
  );

  // decouples front end stalls from output back pressure
  eafrx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .word_i  (push_word),
    .full_o  (q_full),
    .valid_o (q_valid),
    .word_o  (q_word),
    .pop_i   (pop)
  );

  // header registers and registered result word
  eafrx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .word_i      (q_word),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule : escaped_api_frame_rx_parser
`default_nettype wire

// ----- rtl/core/eafrx_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eafrx_front - framing front end
// Hunts for the start delimiter, strips escapes, counts frame bytes and
// tags each one with its header slot, result and end-of-frame flags.
// ----------------------------------------------------------------------------
module eafrx_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            byte_valid_i,
  output logic                 byte_ready_o,
  input  wire logic [7:0]      byte_i,
  output logic                 push_o,
  output eafrx_pkg::word_t     word_o,
  input  wire logic            full_i
);
  import eafrx_pkg::*;

  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      len_hi_q, len_hi_d;
  logic [15:0]     len_q, len_d;

  logic            accept;
  logic [7:0]      ub;
  logic [15:0]     len_now;
  logic [IdxW-1:0] end_cnt;
  slot_e           slot;
  logic            last;

  assign byte_ready_o = !full_i;
  assign accept       = byte_valid_i && !full_i;

  assign ub      = esc_q ? unescape(byte_i) : byte_i;
  assign len_now = (idx_q == IdxW'(2)) ? {len_hi_q, ub} : len_q;
  assign end_cnt = IdxW'(len_now) + IdxW'(EndOfs);
  assign last    = (idx_q == end_cnt);

  // slot decoder, only the header counts carry a slot
  always_comb begin
    slot = SLOT_NONE;
    if (idx_q <= IdxW'(HdrBytes)) begin
      unique case (idx_q[3:0]) inside
        4'd1:                   slot = SLOT_LEN_HI;
        4'd2:                   slot = SLOT_LEN_LO;
        4'd3:                   slot = SLOT_TYPE;
        4'd4, 4'd5, 4'd6, 4'd7: slot = SLOT_ADDR;
        4'd8:                   slot = SLOT_DPORT_HI;
        4'd9:                   slot = SLOT_DPORT_LO;
        4'd10:                  slot = SLOT_SPORT_HI;
        4'd11:                  slot = SLOT_SPORT_LO;
        4'd12:                  slot = SLOT_PROTO;
        4'd13:                  slot = SLOT_STATUS;
        default:                slot = SLOT_NONE;
      endcase
    end
  end

  always_comb begin
    in_frame_d  = in_frame_q;
    esc_d       = esc_q;
    idx_d       = idx_q;
    len_hi_d    = len_hi_q;
    len_d       = len_q;
    push_o      = 1'b0;
    word_o.data = ub;
    word_o.slot = slot;
    word_o.last = last;
    word_o.emit = last || (idx_q > IdxW'(HdrBytes));
    if (accept) begin
      if (!in_frame_q) begin
        if (byte_i == StartDelim) begin
          in_frame_d = 1'b1;
          esc_d      = 1'b0;
          idx_d      = IdxW'(1);
          len_d      = '0;
          len_hi_d   = '0;
        end
      end else if (byte_i == EscByte) begin
        esc_d = 1'b1;
      end else begin
        esc_d  = 1'b0;
        push_o = 1'b1;
        len_d  = len_now;
        if (idx_q == IdxW'(1)) begin
          len_hi_d = ub;
        end
        if (last) begin
          in_frame_d = 1'b0;
          idx_d      = IdxW'(1);
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      idx_q      <= IdxW'(1);
      len_hi_q   <= '0;
      len_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      idx_q      <= idx_d;
      len_hi_q   <= len_hi_d;
      len_q      <= len_d;
    end
  end

endmodule : eafrx_front
`default_nettype wire

// ----- rtl/core/eafrx_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eafrx_queue - short word queue between front and back end
// Small circular buffer; full stalls the front, empty idles the back.
// ----------------------------------------------------------------------------
module eafrx_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  eafrx_pkg::word_t      word_i,
  output logic                  full_o,
  output logic                  valid_o,
  output eafrx_pkg::word_t      word_o,
  input  wire logic             pop_i
);
  import eafrx_pkg::*;

  word_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
    end
  end

endmodule : eafrx_queue
`default_nettype wire

// ----- rtl/core/eafrx_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eafrx_back - header registers and result output stage
// Loads header fields from tagged words and registers one result word
// per payload or end byte, with the header as it stands after that byte.
// ----------------------------------------------------------------------------
module eafrx_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  eafrx_pkg::word_t           word_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [eafrx_pkg::OutDataW-1:0] out_data_o,
  output logic                       out_last_o
);
  import eafrx_pkg::*;

  logic [7:0]  hold_q, hold_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] dport_q, dport_d;
  logic [15:0] sport_q, sport_d;
  logic [7:0]  proto_q, proto_d;
  logic [7:0]  status_q, status_d;

  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;
  logic                load_out;

  assign pop_o    = valid_i && (!out_valid_q || out_ready_i);
  assign load_out = pop_o && word_i.emit;

  always_comb begin
    hold_d   = hold_q;
    len_d    = len_q;
    type_d   = type_q;
    addr_d   = addr_q;
    dport_d  = dport_q;
    sport_d  = sport_q;
    proto_d  = proto_q;
    status_d = status_q;
    if (pop_o) begin
      unique case (word_i.slot)
        SLOT_LEN_HI: begin
          // first byte of a frame: drop the old header
          hold_d   = word_i.data;
          len_d    = '0;
          type_d   = '0;
          addr_d   = '0;
          dport_d  = '0;
          sport_d  = '0;
          proto_d  = '0;
          status_d = '0;
        end
        SLOT_LEN_LO:   len_d    = {hold_q, word_i.data};
        SLOT_TYPE:     type_d   = word_i.data;
        SLOT_ADDR:     addr_d   = {addr_q[23:0], word_i.data};
        SLOT_DPORT_HI: hold_d   = word_i.data;
        SLOT_DPORT_LO: dport_d  = {hold_q, word_i.data};
        SLOT_SPORT_HI: hold_d   = word_i.data;
        SLOT_SPORT_LO: sport_d  = {hold_q, word_i.data};
        SLOT_PROTO:    proto_d  = word_i.data;
        SLOT_STATUS:   status_d = word_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= '0;
      len_q       <= '0;
      type_q      <= '0;
      addr_q      <= '0;
      dport_q     <= '0;
      sport_q     <= '0;
      proto_q     <= '0;
      status_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hold_q      <= hold_d;
      len_q       <= len_d;
      type_q      <= type_d;
      addr_q      <= addr_d;
      dport_q     <= dport_d;
      sport_q     <= sport_d;
      proto_q     <= proto_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {len_d, status_d, proto_d, sport_d, dport_d, addr_d, type_d,
                     word_i.data};
      out_last_q <= word_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule : eafrx_back
`default_nettype wire

// ----- verif/escaped_api_frame_rx_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escaped_api_frame_rx_parser_tb - self-checking bench of the frame parser
// Feeds raw link bytes (a short directed table, then random escaped frames
// with noise in between) and checks every master word, field by field,
// against an in-bench model of the unescape, header and payload logic.
// ----------------------------------------------------------------------------
module escaped_api_frame_rx_parser_tb;
  import eafrx_pkg::*;

  // One result word as the parser presents it
  typedef struct packed {
    logic [7:0]  pay;
    logic        last;
    logic [7:0]  ftype;
    logic [31:0] addr;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [7:0]  proto;
    logic [7:0]  status;
    logic [15:0] len;
  } frame_word_t;

  // Directed row: raw byte, and where chk is set the word it must close with
  typedef struct packed {
    logic [7:0]  raw;
    logic        chk;
    logic [7:0]  pay;
    logic        last;
    logic [7:0]  ftype;
    logic [15:0] len;
  } dir_row_t;

  localparam int DirRows = 28;
  localparam dir_row_t DirTable [0:DirRows-1] = '{
    // noise outside a frame, dropped
    '{8'h55, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    // length 0: the type byte is also the checksum
    '{8'h7E, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'hFF, 1'b1, 8'hFF, 1'b1, 8'hFF, 16'h0000},
    // length 1 sent as a repeated escape of a plain value, delimiter as the
    // type byte, then an escaped 0x7E closes the frame in the address
    '{8'h7E, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h7D, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h7D, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h01, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h7E, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h7D, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h5E, 1'b1, 8'h7E, 1'b1, 8'h7E, 16'h0001},
    // full header, length 11: first byte past the header is the checksum
    '{8'h7E, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h0B, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h92, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'hC0, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'hA8, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h01, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h02, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h1F, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h90, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h50, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h06, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 16'h0000},
    '{8'h5A, 1'b1, 8'h5A, 1'b1, 8'h92, 16'h000B}
  };

  localparam int RandBytes = 500;

  logic           clk_i;
  logic           rst_ni;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [7:0]     s_axis_tdata;   // rx_byte[7:0]
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic [111:0]   m_axis_tdata;   // payload, type, addr, dport, sport, proto, status, len
  logic           m_axis_tlast;   // frame_end

  escaped_api_frame_rx_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Model state of the parser
  bit          p_in_frame;
  bit          p_esc;
  logic [16:0] p_idx;
  logic [7:0]  p_hold;
  logic [15:0] p_len;
  logic [7:0]  p_type;
  logic [31:0] p_addr;
  logic [15:0] p_dport;
  logic [15:0] p_sport;
  logic [7:0]  p_proto;
  logic [7:0]  p_status;

  frame_word_t expected_words[$];
  int          mismatches;
  int          frame_bytes;
  bit          stall_on;      // idling on both sides; off gives full-rate stretches
  int          rdy_hold;
  frame_word_t got_word;
  frame_word_t want_word;
  string       diff_names;

  function automatic bit is_esc_set(input logic [7:0] v);
    return v == StartDelim || v == EscByte || v == XonByte || v == XoffByte;
  endfunction

  function automatic string word_str(input frame_word_t w);
    return $sformatf({"pay=%02h last=%0b type=%02h addr=%08h dport=%04h sport=%04h ",
                      "proto=%02h status=%02h len=%04h"},
                     w.pay, w.last, w.ftype, w.addr, w.dport, w.sport,
                     w.proto, w.status, w.len);
  endfunction

  function automatic string field_diff(input frame_word_t e, input frame_word_t a);
    string s;
    s = "";
    if (e.pay    !== a.pay)    s = {s, " payload_byte"};
    if (e.last   !== a.last)   s = {s, " frame_end"};
    if (e.ftype  !== a.ftype)  s = {s, " frame_type"};
    if (e.addr   !== a.addr)   s = {s, " source_address"};
    if (e.dport  !== a.dport)  s = {s, " destination_port"};
    if (e.sport  !== a.sport)  s = {s, " source_port"};
    if (e.proto  !== a.proto)  s = {s, " protocol_code"};
    if (e.status !== a.status) s = {s, " status_code"};
    if (e.len    !== a.len)    s = {s, " frame_length"};
    return s;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic clear_header();
    p_hold   = '0;
    p_len    = '0;
    p_type   = '0;
    p_addr   = '0;
    p_dport  = '0;
    p_sport  = '0;
    p_proto  = '0;
    p_status = '0;
  endtask

  // Advance the model by one raw byte; got tells whether a word results
  task automatic predict_rx_byte(input logic [7:0] raw, output bit got,
                                 output frame_word_t w);
    logic [7:0]  b;
    logic [16:0] end_cnt;
    b   = raw;
    got = 1'b0;
    w   = '0;
    if (!p_in_frame) begin
      // outside a frame only the delimiter matters: it opens a fresh header
      if (b == StartDelim) begin
        p_in_frame = 1'b1;
        p_esc      = 1'b0;
        p_idx      = 17'd1;
        clear_header();
      end
      return;
    end
    // escape byte is swallowed, also when one is already pending
    if (b == EscByte) begin
      p_esc = 1'b1;
      return;
    end
    if (p_esc) begin
      if (is_esc_set(b ^ EscXor)) b = b ^ EscXor;
      p_esc = 1'b0;
    end
    case (p_idx)
      17'd1:                      p_hold   = b;
      17'd2:                      p_len    = {p_hold, b};
      17'd3:                      p_type   = b;
      17'd4, 17'd5, 17'd6, 17'd7: p_addr   = {p_addr[23:0], b};
      17'd8:                      p_hold   = b;
      17'd9:                      p_dport  = {p_hold, b};
      17'd10:                     p_hold   = b;
      17'd11:                     p_sport  = {p_hold, b};
      17'd12:                     p_proto  = b;
      17'd13:                     p_status = b;
      default: ;
    endcase
    w.pay    = b;
    w.ftype  = p_type;
    w.addr   = p_addr;
    w.dport  = p_dport;
    w.sport  = p_sport;
    w.proto  = p_proto;
    w.status = p_status;
    w.len    = p_len;
    end_cnt  = {1'b0, p_len} + 17'(EndOfs);
    // checksum closes the frame, even inside the header for short lengths
    if (p_idx >= end_cnt) begin
      w.last     = 1'b1;
      got        = 1'b1;
      p_in_frame = 1'b0;
      p_esc      = 1'b0;
      p_idx      = 17'd1;
    end else begin
      got   = (p_idx > 17'(HdrBytes));
      p_idx = p_idx + 17'd1;
    end
  endtask

  // Present one byte after a random gap, wait for the handshake, predict
  task automatic send_byte(input logic [7:0] b, output bit got, output frame_word_t w);
    int gap;
    gap = stall_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_rx_byte(b, got, w);
    if (got) expected_words.push_back(w);
  endtask

  // Send one frame data value on the link, escaped in one of the legal ways
  task automatic send_value(input logic [7:0] v);
    int          c;
    bit          got;
    frame_word_t w;
    c = $urandom_range(0, 15);
    frame_bytes++;
    if (v == EscByte || (is_esc_set(v) && c < 8)) begin
      send_byte(EscByte, got, w);
      if (c == 0) send_byte(EscByte, got, w);
      send_byte(v ^ EscXor, got, w);
    end else if (c == 1 && !is_esc_set(v ^ EscXor)) begin
      // escape in front of a value outside the set leaves it unchanged
      send_byte(EscByte, got, w);
      send_byte(v, got, w);
    end else begin
      send_byte(v, got, w);
    end
  endtask

  task automatic send_frame();
    int          r;
    logic [15:0] flen;
    bit          got;
    frame_word_t w;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      flen = 16'($urandom_range(0, 10));      // ends inside the header
    end else if (r < 19 && frame_bytes + 300 <= RandBytes) begin
      flen = 16'(256 + $urandom_range(0, 40)); // high length byte in use
    end else begin
      flen = 16'($urandom_range(11, 40));
    end
    frame_bytes++;
    send_byte(StartDelim, got, w);
    send_value(flen[15:8]);
    send_value(flen[7:0]);
    for (int i = 3; i <= int'(flen) + 3; i++) begin
      send_value(8'($urandom_range(0, 255)));
    end
  endtask

  // Master side: check each word taken, then draw the next ready stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rdy_hold = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_word.pay    = m_axis_tdata[7:0];
        got_word.last   = m_axis_tlast;
        got_word.ftype  = m_axis_tdata[15:8];
        got_word.addr   = m_axis_tdata[47:16];
        got_word.dport  = m_axis_tdata[63:48];
        got_word.sport  = m_axis_tdata[79:64];
        got_word.proto  = m_axis_tdata[87:80];
        got_word.status = m_axis_tdata[95:88];
        got_word.len    = m_axis_tdata[111:96];
        if (expected_words.size() == 0) begin
          note_mismatch({"unexpected word ", word_str(got_word)});
        end else begin
          want_word  = expected_words.pop_front();
          diff_names = field_diff(want_word, got_word);
          if (diff_names != "") begin
            note_mismatch({"field", diff_names, "\n  exp ", word_str(want_word),
                           "\n  act ", word_str(got_word)});
          end
        end
        rdy_hold = stall_on ? $urandom_range(0, 3) : 0;
        m_axis_tready <= (rdy_hold == 0);
      end else if (rdy_hold != 0) begin
        rdy_hold = rdy_hold - 1;
        m_axis_tready <= (rdy_hold == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    bit          got;
    frame_word_t w;
    int          noise;
    logic [7:0]  nb;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    rst_ni        <= 1'b0;
    stall_on    = 1'b1;
    mismatches  = 0;
    frame_bytes = 0;
    p_in_frame  = 1'b0;
    p_esc       = 1'b0;
    p_idx       = 17'd1;
    clear_header();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; typed rows also pin down the model itself
    for (int i = 0; i < DirRows; i++) begin
      send_byte(DirTable[i].raw, got, w);
      if (DirTable[i].chk) begin
        if (!got || w.pay !== DirTable[i].pay || w.last !== DirTable[i].last ||
            w.ftype !== DirTable[i].ftype || w.len !== DirTable[i].len) begin
          note_mismatch($sformatf("table row %0d: exp pay=%02h last=%0b type=%02h len=%04h",
                                  i, DirTable[i].pay, DirTable[i].last,
                                  DirTable[i].ftype, DirTable[i].len));
        end
      end
    end

    // random frames, a little line noise between them
    while (frame_bytes < RandBytes) begin
      stall_on = ($urandom_range(0, 3) != 0);
      noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int k = 0; k < noise; k++) begin
        nb = 8'($urandom_range(0, 255));
        if (nb == StartDelim) nb = EscByte;
        send_byte(nb, got, w);
      end
      send_frame();
    end
    s_axis_tvalid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("escaped_api_frame_rx_parser_tb OK");
    end else begin
      $display("escaped_api_frame_rx_parser_tb NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #5000000;
    $display("escaped_api_frame_rx_parser_tb NOT OK");
    $finish;
  end

endmodule
